// ----- rtl/core/bgr_pkg.sv -----
// shared types and constants of the glyph renderer
// used by every module of the block but bgr_ram, depends on nothing

package bgr_pkg;

  localparam int ADDR_W     = 48;
  localparam int COLOUR_W   = 32;
  // glyph store address width of a command; the default store needs 11 bits
  localparam int CMD_ADDR_W = 15;

  localparam logic [2:0] CFG_FRAME_BASE  = 3'd0;
  localparam logic [2:0] CFG_LINE_PITCH  = 3'd1;
  localparam logic [2:0] CFG_PIXEL_BYTES = 3'd2;
  localparam logic [2:0] CFG_GLYPH_COUNT = 3'd3;
  localparam logic [2:0] CFG_GLYPH_COLS  = 3'd4;
  localparam logic [2:0] CFG_GLYPH_ROWS  = 3'd5;

  typedef struct packed {
    logic                mode;
    logic [20:0]         char_code;
    logic [15:0]         cursor_col;
    logic [15:0]         cursor_row;
    logic [15:0]         offset_x;
    logic [15:0]         offset_y;
    logic [COLOUR_W-1:0] fg_colour;
    logic [COLOUR_W-1:0] bg_colour;
    logic [7:0]          load_glyph;
    logic [2:0]          load_row;
    logic [7:0]          row_bits;
  } bgr_in_t;

  typedef struct packed {
    logic [ADDR_W-1:0]   pixel_address;
    logic [COLOUR_W-1:0] pixel_colour;
    logic                last;
  } bgr_out_t;

  // cols and rows arrive already clamped to the glyph maxima
  typedef struct packed {
    logic [ADDR_W-1:0] frame_base;
    logic [15:0]       line_pitch;
    logic [2:0]        pixel_bytes;
    logic [8:0]        glyph_count;
    logic [3:0]        glyph_cols;
    logic [3:0]        glyph_rows;
  } bgr_cfg_t;

  // one classified item on its way to the pixel sequencer
  typedef struct packed {
    logic                  is_draw;
    logic [CMD_ADDR_W-1:0] addr;
    logic [7:0]            row_bits;
    logic [ADDR_W-1:0]     start;
    logic [COLOUR_W-1:0]   fg;
    logic [COLOUR_W-1:0]   bg;
  } bgr_cmd_t;

endpackage

// ----- rtl/core/bitmap_glyph_renderer.sv -----
// top level of the glyph renderer: register file, front end, command queue,
// pixel sequencer and glyph store; depends on bgr_pkg and all bgr_ modules

// A load transaction writes one 8-bit row of one glyph into the glyph store;
// a draw transaction emits cols*rows pixel writes, row by row, the last one
// marked. The pixel sequencer puts out one pixel per cycle unless the receiver
// stalls, after first fetching the first glyph row of a draw from the store;
// a load occupies it only for its store write. The front end works out the
// start address of a draw in its CELL, SCALE and SUM states, while a load goes
// straight to PUSH; it is overlapped with the sequencer through a
// two-entry queue, but takes a new item only once the last one is pushed. The
// glyph store is not cleared at reset: a row must be loaded before it is
// drawn. Configuration must be written only while the block is idle.

module bitmap_glyph_renderer #(
  parameter int MAX_GLYPHS  = 256,
  parameter int MAX_GLYPH_W = 8,
  parameter int MAX_GLYPH_H = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [2:0]        cfg_index,
  input  logic [47:0]       cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  bgr_pkg::bgr_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output bgr_pkg::bgr_out_t out_data
);
  import bgr_pkg::*;

  localparam int STORE_DEPTH = MAX_GLYPHS * MAX_GLYPH_H;
  localparam int STORE_AW    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  logic [ADDR_W-1:0] frame_base;
  logic [15:0]       line_pitch;
  logic [2:0]        pixel_bytes;
  logic [8:0]        glyph_count;
  logic [3:0]        glyph_cols;
  logic [3:0]        glyph_rows;

  bgr_cfg_t cfg;
  bgr_cmd_t front_cmd, q_head;
  logic     push, q_full, q_valid, pop;

  logic                ram_we, ram_re;
  logic [STORE_AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]          ram_wdata, ram_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_base  <= '0;
      line_pitch  <= 16'd4096;
      pixel_bytes <= 3'd4;
      glyph_count <= 9'd256;
      glyph_cols  <= 4'd8;
      glyph_rows  <= 4'd8;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_FRAME_BASE:  frame_base  <= cfg_data;
        CFG_LINE_PITCH:  line_pitch  <= cfg_data[15:0];
        CFG_PIXEL_BYTES: pixel_bytes <= cfg_data[2:0];
        CFG_GLYPH_COUNT: glyph_count <= cfg_data[8:0];
        CFG_GLYPH_COLS:  glyph_cols  <= cfg_data[3:0];
        CFG_GLYPH_ROWS:  glyph_rows  <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // oversized glyph dimensions saturate to the store's maxima
  always_comb begin
    cfg.frame_base  = frame_base;
    cfg.line_pitch  = line_pitch;
    cfg.pixel_bytes = pixel_bytes;
    cfg.glyph_count = glyph_count;
    cfg.glyph_cols  = (32'(glyph_cols) > 32'(MAX_GLYPH_W)) ? 4'(MAX_GLYPH_W) : glyph_cols;
    cfg.glyph_rows  = (32'(glyph_rows) > 32'(MAX_GLYPH_H)) ? 4'(MAX_GLYPH_H) : glyph_rows;
  end

  bgr_front #(
    .MAX_GLYPHS  (MAX_GLYPHS),
    .MAX_GLYPH_H (MAX_GLYPH_H)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .push     (push),
    .cmd      (front_cmd),
    .q_full   (q_full)
  );

  bgr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (front_cmd),
    .full     (q_full),
    .pop      (pop),
    .head     (q_head),
    .valid    (q_valid)
  );

  bgr_back #(
    .DEPTH (STORE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .pop       (pop),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  bgr_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

// ----- rtl/core/bgr_ram.sv -----
// generic simple dual-port ram, one write and one registered read port
// no dependencies

module bgr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/bgr_front.sv -----
// front end: accepts items, checks loads, picks the glyph and works out
// the start address of a draw; depends on bgr_pkg

module bgr_front #(
  parameter int MAX_GLYPHS  = 256,
  parameter int MAX_GLYPH_H = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  bgr_pkg::bgr_cfg_t cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  bgr_pkg::bgr_in_t  in_data,
  output logic              push,
  output bgr_pkg::bgr_cmd_t cmd,
  input  logic              q_full
);
  import bgr_pkg::*;

  typedef enum logic [2:0] {
    IDLE,
    CELL,
    SCALE,
    SUM,
    PUSH
  } state_t;

  state_t      state;
  logic [15:0] crow, ccol, offx, offy;
  logic [20:0] py, px;
  logic [36:0] ty;
  logic [23:0] tx;

  logic        load_ok;
  logic        code_ok;
  logic [20:0] sel_code;

  assign load_ok  = (32'(in_data.load_glyph) < 32'(MAX_GLYPHS)) &&
                    (32'(in_data.load_row) < 32'(MAX_GLYPH_H));
  assign code_ok  = (in_data.char_code != '0) &&
                    (32'(in_data.char_code) < 32'(cfg.glyph_count)) &&
                    (32'(in_data.char_code) < 32'(MAX_GLYPHS));
  assign sel_code = code_ok ? in_data.char_code : '0;

  assign in_ready = (state == IDLE);
  assign push     = (state == PUSH) && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      unique case (state)
        IDLE: begin
          if (in_valid) begin
            cmd.fg       <= in_data.fg_colour;
            cmd.bg       <= in_data.bg_colour;
            cmd.row_bits <= in_data.row_bits;
            crow         <= in_data.cursor_row;
            ccol         <= in_data.cursor_col;
            offx         <= in_data.offset_x;
            offy         <= in_data.offset_y;
            if (!in_data.mode) begin
              cmd.is_draw <= 1'b0;
              cmd.addr    <= CMD_ADDR_W'(32'(in_data.load_glyph) * MAX_GLYPH_H +
                                         32'(in_data.load_row));
              // out of range loads are dropped here
              if (load_ok) begin
                state <= PUSH;
              end
            end else begin
              cmd.is_draw <= 1'b1;
              cmd.addr    <= CMD_ADDR_W'(32'(sel_code) * MAX_GLYPH_H);
              // an empty glyph size draws nothing
              if (cfg.glyph_cols != '0 && cfg.glyph_rows != '0) begin
                state <= CELL;
              end
            end
          end
        end
        CELL: begin
          py    <= 21'(crow) * 21'(cfg.glyph_rows) + 21'(offy);
          px    <= 21'(ccol) * 21'(cfg.glyph_cols) + 21'(offx);
          state <= SCALE;
        end
        SCALE: begin
          ty    <= 37'(py) * 37'(cfg.line_pitch);
          tx    <= 24'(px) * 24'(cfg.pixel_bytes);
          state <= SUM;
        end
        SUM: begin
          cmd.start <= cfg.frame_base + ADDR_W'(ty) + ADDR_W'(tx);
          state     <= PUSH;
        end
        PUSH: begin
          if (!q_full) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/core/bgr_queue.sv -----
// two-entry command queue between front end and pixel sequencer
// depends on bgr_pkg

module bgr_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  bgr_pkg::bgr_cmd_t push_cmd,
  output logic              full,
  input  logic              pop,
  output bgr_pkg::bgr_cmd_t head,
  output logic              valid
);
  import bgr_pkg::*;

  bgr_cmd_t    entries [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;

  assign full  = (count == 2'd2);
  assign valid = (count != 2'd0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- rtl/core/bgr_back.sv -----
// back end: writes glyph rows and walks the pixels of a draw, one per cycle unless the receiver stalls
// depends on bgr_pkg; drives the glyph store ports

module bgr_back #(
  parameter int DEPTH = 2048,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  bgr_pkg::bgr_cfg_t cfg,
  input  logic              q_valid,
  input  bgr_pkg::bgr_cmd_t q_head,
  output logic              pop,
  output logic              ram_we,
  output logic [AW-1:0]     ram_waddr,
  output logic [7:0]        ram_wdata,
  output logic              ram_re,
  output logic [AW-1:0]     ram_raddr,
  input  logic [7:0]        ram_rdata,
  output logic              out_valid,
  input  logic              out_ready,
  output bgr_pkg::bgr_out_t out_data
);
  import bgr_pkg::*;

  typedef enum logic {
    IDLE,
    EMIT
  } state_t;

  state_t              state;
  logic [AW-1:0]       glyph_base;
  logic [COLOUR_W-1:0] fg, bg;
  logic [2:0]          x, y;
  logic [ADDR_W-1:0]   row_addr;
  logic [ADDR_W-1:0]   pix_addr;

  logic              slot_free;
  logic              step;
  logic              x_end;
  logic              y_end;
  logic [2:0]        y_next;
  logic [ADDR_W-1:0] row_addr_next;

  assign slot_free     = !out_valid || out_ready;
  assign step          = (state == EMIT) && slot_free;
  assign x_end         = ({1'b0, x} == cfg.glyph_cols - 4'd1);
  assign y_end         = ({1'b0, y} == cfg.glyph_rows - 4'd1);
  assign y_next        = y + 3'd1;
  assign row_addr_next = row_addr + ADDR_W'(cfg.line_pitch);

  assign pop       = (state == IDLE) && q_valid;
  assign ram_we    = pop && !q_head.is_draw;
  assign ram_waddr = AW'(q_head.addr);
  assign ram_wdata = q_head.row_bits;

  // the read data holds between reads, so it serves as the current row
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = AW'(q_head.addr);
    if (pop && q_head.is_draw) begin
      ram_re = 1'b1;
    end else if (step && x_end && !y_end) begin
      ram_re    = 1'b1;
      ram_raddr = glyph_base + AW'(y_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      if (step) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        IDLE: begin
          if (pop && q_head.is_draw) begin
            glyph_base <= AW'(q_head.addr);
            fg         <= q_head.fg;
            bg         <= q_head.bg;
            row_addr   <= q_head.start;
            pix_addr   <= q_head.start;
            x          <= 3'd0;
            y          <= 3'd0;
            state      <= EMIT;
          end
        end
        EMIT: begin
          if (step) begin
            out_data.pixel_address <= pix_addr;
            out_data.pixel_colour  <= ram_rdata[~x] ? fg : bg;
            out_data.last          <= x_end && y_end;
            if (x_end) begin
              x        <= 3'd0;
              y        <= y_next;
              row_addr <= row_addr_next;
              pix_addr <= row_addr_next;
              if (y_end) begin
                state <= IDLE;
              end
            end else begin
              x        <= x + 3'd1;
              pix_addr <= pix_addr + ADDR_W'(cfg.pixel_bytes);
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// ----- verif/tb_bitmap_glyph_renderer.sv -----
`timescale 1ns / 100ps
// self-checking testbench of bitmap_glyph_renderer: glyph row loads and character draws,
// directed then random, every pixel write compared against a behavioral model
// depends on bgr_pkg and the renderer rtl

module tb_bitmap_glyph_renderer;
  import bgr_pkg::*;

  localparam int GLYPH_LIMIT  = 256;
  localparam int COL_LIMIT    = 8;
  localparam int ROW_LIMIT    = 8;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 64;
  localparam int LONG_HOLD    = 500;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_DRAW = 1'b1;

  localparam logic [63:0] GLYPH0_ROWS = 64'h80_01_FF_00_AA_55_81_7E;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [2:0]  cfg_index = CFG_FRAME_BASE;
  logic [47:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  bgr_in_t     in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  bgr_out_t    out_data;

  // register copies, reset values of the block
  logic [47:0] frame_base  = '0;
  logic [15:0] line_pitch  = 16'd4096;
  logic [2:0]  pixel_bytes = 3'd4;
  logic [8:0]  glyph_count = 9'd256;
  logic [3:0]  glyph_cols  = 4'd8;
  logic [3:0]  glyph_rows  = 4'd8;

  logic [7:0] font_rows [GLYPH_LIMIT*ROW_LIMIT];
  // rows already queued for loading, per glyph; a glyph is drawn only once all are set
  logic [7:0] row_loaded [GLYPH_LIMIT];
  int         ready_glyphs [$];

  bgr_in_t  pending_items [$];
  bgr_out_t pix_expected [$];
  bgr_out_t next_pixel;

  bit          in_busy = 1'b0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_req = 1'b0;
  int unsigned hold_left = 0;
  int unsigned cycles = 0;
  int unsigned mismatches = 0;

  bitmap_glyph_renderer #(
    .MAX_GLYPHS (GLYPH_LIMIT),
    .MAX_GLYPH_W(COL_LIMIT),
    .MAX_GLYPH_H(ROW_LIMIT)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #4 clk = ~clk;

  // codes of zero or past the valid glyphs fall back to glyph 0
  function automatic logic [7:0] glyph_of(input logic [20:0] code);
    if (code != 0 && code < glyph_count && code < GLYPH_LIMIT) return code[7:0];
    return 8'd0;
  endfunction

  task automatic render_pixels(input bgr_in_t it);
    logic [63:0] cols;
    logic [63:0] rows;
    logic [63:0] start;
    logic [63:0] rowaddr;
    logic [63:0] addr;
    logic [7:0]  g;
    logic [7:0]  bits;
    bgr_out_t    px;
    cols = (glyph_cols > COL_LIMIT) ? COL_LIMIT : glyph_cols;
    rows = (glyph_rows > ROW_LIMIT) ? ROW_LIMIT : glyph_rows;
    if (cols == 0 || rows == 0) return;
    g = glyph_of(it.char_code);
    start = frame_base + (it.cursor_row * rows + it.offset_y) * line_pitch
            + (it.cursor_col * cols + it.offset_x) * pixel_bytes;
    for (int y = 0; y < rows; y++) begin
      bits = font_rows[g * ROW_LIMIT + y];
      rowaddr = start + y * line_pitch;
      for (int x = 0; x < cols; x++) begin
        addr = rowaddr + x * pixel_bytes;
        px.pixel_address = addr[47:0];
        px.pixel_colour  = bits[7 - x] ? it.fg_colour : it.bg_colour;
        px.last          = (y == rows - 1) && (x == cols - 1);
        pix_expected.push_back(px);
      end
    end
  endtask

  function automatic bgr_in_t random_item();
    bgr_in_t it;
    it.mode       = 1'($urandom_range(1));
    it.char_code  = 21'($urandom);
    it.cursor_col = 16'($urandom);
    it.cursor_row = 16'($urandom);
    it.offset_x   = 16'($urandom);
    it.offset_y   = 16'($urandom);
    it.fg_colour  = $urandom;
    it.bg_colour  = $urandom;
    it.load_glyph = 8'($urandom);
    it.load_row   = 3'($urandom);
    it.row_bits   = 8'($urandom);
    return it;
  endfunction

  task automatic push_load(input logic [7:0] g, input logic [2:0] r, input logic [7:0] bits);
    bgr_in_t it;
    it = random_item();
    it.mode       = MODE_LOAD;
    it.load_glyph = g;
    it.load_row   = r;
    it.row_bits   = bits;
    pending_items.push_back(it);
    if (row_loaded[g] != 8'hFF) begin
      row_loaded[g][r] = 1'b1;
      if (row_loaded[g] == 8'hFF) ready_glyphs.push_back(g);
    end
  endtask

  // never draw a glyph with rows still unwritten, glyph 0 is always complete
  task automatic push_draw(input bgr_in_t it);
    it.mode = MODE_DRAW;
    if (row_loaded[glyph_of(it.char_code)] != 8'hFF) it.char_code = '0;
    pending_items.push_back(it);
  endtask

  task automatic push_random(input int n);
    int        done;
    int        pick;
    logic [7:0] g;
    bgr_in_t   it;
    done = 0;
    while (done < n) begin
      pick = $urandom_range(99);
      if (pick < 15) begin
        // define a whole glyph, later draws can pick it
        g = 8'($urandom_range(255));
        for (int r = 0; r < ROW_LIMIT; r++) push_load(g, 3'(r), 8'($urandom_range(255)));
        done += ROW_LIMIT;
      end else if (pick < 30) begin
        push_load(8'($urandom_range(255)), 3'($urandom_range(7)), 8'($urandom_range(255)));
        done++;
      end else begin
        it = random_item();
        case ($urandom_range(3))
          0, 1: it.char_code = 21'(ready_glyphs[$urandom_range(ready_glyphs.size() - 1)]);
          2: it.char_code = 21'($urandom_range(511));
          default: ;
        endcase
        push_draw(it);
        done++;
      end
    end
  endtask

  task automatic wait_idle();
    while (pending_items.size() != 0 || in_busy || pix_expected.size() != 0) @(negedge clk);
    // loads and empty draws leave no result behind, give them time to retire
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [47:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
  endtask

  task automatic program_setup(input logic [47:0] base, input logic [15:0] pitch,
                               input logic [2:0] pbytes, input logic [8:0] count,
                               input logic [3:0] cols, input logic [3:0] rows);
    wait_idle();
    write_reg(CFG_FRAME_BASE, base);
    write_reg(CFG_LINE_PITCH, pitch);
    write_reg(CFG_PIXEL_BYTES, pbytes);
    write_reg(CFG_GLYPH_COUNT, count);
    write_reg(CFG_GLYPH_COLS, cols);
    write_reg(CFG_GLYPH_ROWS, rows);
    @(negedge clk);
    cfg_write <= 1'b0;
    frame_base  = base;
    line_pitch  = pitch;
    pixel_bytes = pbytes;
    glyph_count = count;
    glyph_cols  = cols;
    glyph_rows  = rows;
  endtask

  // input side: model update on acceptance, next transaction offered at the falling edge
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      if (in_data.mode == MODE_LOAD) begin
        if (in_data.load_glyph < GLYPH_LIMIT && in_data.load_row < ROW_LIMIT)
          font_rows[in_data.load_glyph * ROW_LIMIT + in_data.load_row] = in_data.row_bits;
      end else begin
        render_pixels(in_data);
      end
      in_busy = 1'b0;
    end
  end

  always @(negedge clk) begin
    if (!rst && !in_busy) begin
      if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data  <= pending_items.pop_front();
        in_valid <= 1'b1;
        in_busy  = 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = LONG_HOLD;
      hold_req  = 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
    end
  end

  always @(negedge clk) begin
    out_ready <= !rst && hold_left == 0 && $urandom_range(99) >= recv_stall_pct;
  end

  // output side and run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout", $time);
      $display("[FAIL] regression broken");
      $finish;
    end
    if (!rst && out_valid && out_ready) begin
      if (pix_expected.size() == 0) begin
        $display("%0t: unexpected pixel write, expected none, got addr %h colour %h last %b",
                 $time, out_data.pixel_address, out_data.pixel_colour, out_data.last);
        mismatches++;
      end else begin
        next_pixel = pix_expected.pop_front();
        if (out_data.pixel_address !== next_pixel.pixel_address ||
            out_data.pixel_colour !== next_pixel.pixel_colour ||
            out_data.last !== next_pixel.last) begin
          $display("%0t: expected addr %h colour %h last %b, got addr %h colour %h last %b",
                   $time, next_pixel.pixel_address, next_pixel.pixel_colour, next_pixel.last,
                   out_data.pixel_address, out_data.pixel_colour, out_data.last);
          mismatches++;
        end
      end
    end
  end

  initial begin
    bgr_in_t it;
    for (int g = 0; g < GLYPH_LIMIT; g++) row_loaded[g] = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: fallback glyph and the highest glyph, extreme positions and colours
    for (int r = 0; r < ROW_LIMIT; r++) push_load(8'h00, 3'(r), GLYPH0_ROWS[63 - 8 * r -: 8]);
    for (int r = 0; r < ROW_LIMIT; r++) push_load(8'hFF, 3'(r), 8'($urandom_range(255)));
    it = random_item();
    it.char_code  = '0;
    it.cursor_col = '0;
    it.cursor_row = '0;
    it.offset_x   = '0;
    it.offset_y   = '0;
    it.fg_colour  = '1;
    it.bg_colour  = '0;
    push_draw(it);
    it = random_item();
    it.char_code  = 21'd255;
    it.cursor_col = '1;
    it.cursor_row = '1;
    it.offset_x   = '1;
    it.offset_y   = '1;
    it.fg_colour  = '0;
    it.bg_colour  = '1;
    push_draw(it);
    it = random_item();
    it.char_code = 21'd256;
    push_draw(it);
    it = random_item();
    it.char_code  = '1;
    it.cursor_col = '0;
    it.cursor_row = '0;
    it.offset_x   = '1;
    it.offset_y   = '1;
    push_draw(it);

    program_setup(48'({$urandom, $urandom}), 16'd4096, 3'd4, 9'd256, 4'd8, 4'd8);
    send_idle_pct  = 54;
    recv_stall_pct = 0;
    push_random(20);

    // address wrap at the top of memory, single pixel glyphs, one valid glyph
    program_setup('1, 16'hFFFF, 3'd1, 9'd1, 4'd1, 4'd1);
    send_idle_pct  = 0;
    recv_stall_pct = 54;
    push_random(16);

    // zero width, zero pitch and pixel size: draws give nothing
    program_setup('0, 16'd0, 3'd0, 9'd0, 4'd0, 4'd15);
    send_idle_pct  = 33;
    recv_stall_pct = 33;
    push_random(6);

    // oversized width saturates, widest pixel step
    program_setup(48'({$urandom, $urandom}), 16'd1, 3'd7, 9'd511, 4'd15, 4'd3);
    push_random(18);

    // receiver holds off long enough for the input to back up
    program_setup(48'({$urandom, $urandom}), 16'($urandom_range(65535)), 3'd2, 9'd100,
                  4'd5, 4'd8);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req = 1'b1;
    push_random(12);

    program_setup(48'({$urandom, $urandom}), 16'd4096, 3'd4, 9'd256, 4'd8, 4'd0);
    push_random(5);

    program_setup(48'({$urandom, $urandom}), 16'($urandom_range(65535)), 3'd3,
                  9'($urandom_range(1, 256)), 4'd3, 4'd7);
    send_idle_pct  = 33;
    recv_stall_pct = 33;
    push_random(14);

    wait_idle();
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
